// ===== src/affine_transform_composer_defines.svh =====
// Assertion macros used by the transform composer top level.
`ifndef AFFINE_TRANSFORM_COMPOSER_DEFINES_SVH
`define AFFINE_TRANSFORM_COMPOSER_DEFINES_SVH
// Overlapping implication checked at every rising clock edge outside reset.
`define ATC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define ATC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/atc_pkg.sv =====
// Package with opcodes, constants and arithmetic types of the transform composer.
`timescale 1ns / 1ps
`default_nettype none
package atc_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF = 20;

    localparam logic [4:0] OP_IDENT  = 5'd0;
    localparam logic [4:0] OP_TRANS  = 5'd1;
    localparam logic [4:0] OP_SCALE  = 5'd2;
    localparam logic [4:0] OP_ROTX   = 5'd3;
    localparam logic [4:0] OP_ROTY   = 5'd4;
    localparam logic [4:0] OP_ROTZ   = 5'd5;
    localparam logic [4:0] OP_PRJXY  = 5'd6;
    localparam logic [4:0] OP_PRJXZ  = 5'd7;
    localparam logic [4:0] OP_PRJYZ  = 5'd8;
    localparam logic [4:0] OP_MIRXY  = 5'd9;
    localparam logic [4:0] OP_MIRXZ  = 5'd10;
    localparam logic [4:0] OP_MIRYZ  = 5'd11;
    localparam logic [4:0] OP_POINT  = 5'd12;
    localparam logic [4:0] OP_VECTOR = 5'd13;
    localparam logic [4:0] OP_WRITE  = 5'd14;
    localparam logic [4:0] OP_READ   = 5'd15;
    localparam logic [4:0] OP_XYZROT = 5'd16;

    localparam logic signed [63:0] CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam logic signed [63:0] DEG_TO_RAD_Q32  = 64'sd74961321;

    typedef logic signed [31:0] t_elem;
    typedef logic signed [63:0] t_acc;

    // Per-lane control travelling from the sequencer to the dot-product lanes.
    typedef struct packed {
        logic clear;
        logic add;
    } t_lane_ctl;

    function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0: v = 32'sd843314857;
            5'd1: v = 32'sd497837829;
            5'd2: v = 32'sd263043837;
            5'd3: v = 32'sd133525159;
            5'd4: v = 32'sd67021687;
            5'd5: v = 32'sd33543516;
            5'd6: v = 32'sd16775851;
            5'd7: v = 32'sd8388437;
            5'd8: v = 32'sd4194283;
            5'd9: v = 32'sd2097149;
            5'd31: v = 32'sd0;
            default: v = 32'sd1 <<< (30 - i);
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== src/atc_cordic.sv =====
// Iterative CORDIC that turns an angle in degrees into rounded sine and cosine.
`timescale 1ns / 1ps
`default_nettype none
module atc_cordic #(
    parameter int FRAC_BITS = atc_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = atc_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic signed [31:0] i_deg,
    output logic             o_done,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ITER = 3'd3;
    localparam logic [2:0] S_GX   = 3'd4;
    localparam logic [2:0] S_GY   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_FOLD = 3'd7;
    localparam int NSTEP = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    // The angle is offset by a multiple of a full turn so that it is positive, and
    // the remainder is then found by one compare and subtract per cycle.
    localparam int KSH = (FRAC_BITS >= 23) ? 0 : 23 - FRAC_BITS;
    localparam logic signed [43:0] FULL = 44'sd360 <<< FRAC_BITS;
    localparam logic signed [43:0] HALF = 44'sd180 <<< FRAC_BITS;
    localparam logic signed [43:0] QUAR = 44'sd90 <<< FRAC_BITS;
    localparam logic signed [43:0] DIV0 = FULL <<< KSH;
    localparam logic signed [35:0] ONE  = 36'sd1 <<< FRAC_BITS;

    logic [2:0] r_state;
    logic [5:0] r_step;
    logic signed [43:0] r_ang;
    logic signed [43:0] r_div;
    logic r_neg;
    logic signed [35:0] r_x, r_y, r_z;
    logic signed [35:0] r_cos, r_sin;
    logic signed [43:0] red, fold;
    logic n_neg;
    logic signed [71:0] zprod;
    logic signed [35:0] dx, dy;
    logic signed [71:0] gprod;
    logic signed [35:0] gx;

    function automatic logic signed [35:0] unit_round(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = (FRAC_BITS == 30) ? v : ((v + (36'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
        if (t > ONE) t = ONE;
        else if (t < -ONE) t = -ONE;
        return t;
    endfunction

    always_comb begin
        red = r_ang;
        if (red >= HALF) red = red - FULL;
        n_neg = 1'b0;
        fold = red;
        if (red > QUAR) begin
            fold = red - HALF;
            n_neg = 1'b1;
        end else if (red < -QUAR) begin
            fold = red + HALF;
            n_neg = 1'b1;
        end
        zprod = 72'(r_ang) * 72'(atc_pkg::DEG_TO_RAD_Q32);
        dx = r_y >>> r_step[4:0];
        dy = r_x >>> r_step[4:0];
        gprod = 72'((r_state == S_GX) ? r_x : r_y) * 72'(atc_pkg::CORDIC_GAIN_Q30);
        gx = 36'((gprod + (72'sd1 <<< 29)) >>> 30);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_ang <= 44'(i_deg) + DIV0;
                        r_div <= DIV0;
                        r_step <= 6'(KSH);
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    if (r_ang >= r_div) r_ang <= r_ang - r_div;
                    r_div <= r_div >>> 1;
                    r_step <= r_step - 6'd1;
                    if (r_step == 6'd0) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_ang <= fold;
                    r_neg <= n_neg;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_z <= 36'((zprod + (72'sd1 <<< (FRAC_BITS + 1))) >>> (FRAC_BITS + 2));
                    r_x <= 36'sd1 <<< 30;
                    r_y <= '0;
                    r_step <= '0;
                    r_state <= (NSTEP == 0) ? S_GX : S_ITER;
                end
                S_ITER: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - 36'(atc_pkg::atan_q30(r_step[4:0]));
                    end else begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + 36'(atc_pkg::atan_q30(r_step[4:0]));
                    end
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'(NSTEP - 1)) r_state <= S_GX;
                end
                S_GX: begin
                    r_cos <= unit_round(gx);
                    r_state <= S_GY;
                end
                S_GY: begin
                    r_sin <= unit_round(gx);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    o_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cos = r_neg ? 32'(-r_cos) : 32'(r_cos);
    assign o_sin = r_neg ? 32'(-r_sin) : 32'(r_sin);
endmodule
`default_nettype wire

// ===== src/atc_lane.sv =====
// One dot-product lane: a 32x32 multiplier and an exact split accumulator.
`timescale 1ns / 1ps
`default_nettype none
module atc_lane #(
    parameter int FRAC_BITS = atc_pkg::FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire atc_pkg::t_lane_ctl i_ctl,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed [31:0] o_res,
    output logic             o_sat
);
    logic signed [63:0] r_prod;
    logic               r_padd;
    logic signed [63:0] r_hi;
    logic signed [63:0] r_lo;
    logic signed [63:0] q;
    logic signed [63:0] fin;

    always_comb begin
        q = r_prod >>> FRAC_BITS;
        fin = r_hi + ((r_lo + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
        r_padd <= i_ctl.add;
        if (i_ctl.clear) begin
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_padd) begin
            r_hi <= r_hi + q;
            r_lo <= r_lo + (r_prod - (q <<< FRAC_BITS));
        end
    end

    always_comb begin
        if (fin > 64'sd2147483647) begin
            o_res = 32'sh7fffffff;
            o_sat = 1'b1;
        end else if (fin < -64'sd2147483648) begin
            o_res = 32'sh80000000;
            o_sat = 1'b1;
        end else begin
            o_res = 32'(fin);
            o_sat = 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== src/affine_transform_composer.sv =====
// Top level of the 4x4 homogeneous transform composer.
// Usage: one command beat enters on i_valid/o_ready with an opcode and three
// Q16.16 operands. Exactly one result beat leaves on o_valid/i_ready.
// The block holds a 4x4 matrix that reset sets to the identity; the reset is
// synchronous, after which commands are taken.
// Four parallel lanes each own one row of the result and accumulate four
// products (three for a vector), one per cycle; a drain state stores the row results.
// Write, read, identity and unused opcodes go from decode through the done state
// to the output state; a composition passes the matrix column by column through
// the lanes; a point or vector passes through the lanes once; a single rotation
// first waits for the CORDIC sine and cosine; the intrinsic XYZ rotation runs
// three rotations back to back.
// The block works on one command at a time and takes the next command only
// once the last result has moved into the output register.
// The result sits in an output register; while the receiver stalls, the block
// takes the next command and only holds before its own result would overwrite
// the waiting one.
`timescale 1ns / 1ps
`default_nettype none
`include "affine_transform_composer_defines.svh"
module affine_transform_composer #(
    parameter int FRAC_BITS = atc_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = atc_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [4:0]  i_opcode,
    input  wire logic signed [31:0] i_operand_a,
    input  wire logic signed [31:0] i_operand_b,
    input  wire logic signed [31:0] i_operand_c,
    input  wire logic [1:0]  i_element_row,
    input  wire logic [1:0]  i_element_col,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [31:0] o_result_x,
    output logic signed [31:0] o_result_y,
    output logic signed [31:0] o_result_z,
    output logic             o_saturated
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_TRIG  = 4'd2;
    localparam logic [3:0] S_TWAIT = 4'd3;
    localparam logic [3:0] S_MAC   = 4'd4;
    localparam logic [3:0] S_DRAIN = 4'd5;
    localparam logic [3:0] S_WB    = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic [3:0] r_state;
    logic [4:0] r_op;
    logic signed [31:0] r_a, r_b, r_c;
    logic [1:0] r_row, r_col;
    logic signed [31:0] r_m [4][4];
    logic signed [31:0] r_t [4][4];
    logic [1:0] r_rot;
    logic [1:0] r_axis;
    logic [1:0] r_col_i;
    logic [2:0] r_k;
    logic r_vecmode;
    logic r_sat;
    logic signed [31:0] r_rx, r_ry, r_rz;
    logic r_pend;

    logic cor_start, cor_done;
    logic signed [31:0] cor_sin, cor_cos, cor_deg;
    atc_pkg::t_lane_ctl lane_ctl;
    logic signed [31:0] lane_a [4];
    logic signed [31:0] lane_b [4];
    logic signed [31:0] lane_res [4];
    logic lane_sat [4];
    logic [1:0] kk;
    logic ost_free;

    atc_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_start), .i_deg(cor_deg),
        .o_done(cor_done), .o_sin(cor_sin), .o_cos(cor_cos)
    );

    for (genvar g = 0; g < 4; g++) begin : g_lane
        atc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk(i_clk), .i_ctl(lane_ctl), .i_a(lane_a[g]), .i_b(lane_b[g]),
            .o_res(lane_res[g]), .o_sat(lane_sat[g])
        );
    end

    assign kk = r_k[1:0];
    assign cor_start = (r_state == S_TRIG);
    assign cor_deg = (r_op == atc_pkg::OP_XYZROT) ?
        ((r_rot == 2'd0) ? r_c : ((r_rot == 2'd1) ? r_b : r_a)) : r_a;
    assign ost_free = !o_valid || i_ready;
    assign o_ready = (r_state == S_IDLE) && !r_pend;

    // Lanes: point/vector mode multiplies M[row][k] by v[k]; compose mode
    // multiplies T[row][k] by M[k][col].
    always_comb begin
        lane_ctl.clear = (r_state == S_DEC) || (r_state == S_WB);
        lane_ctl.add = (r_state == S_MAC) && !(r_vecmode && r_op == atc_pkg::OP_VECTOR
            && kk == 2'd3);
        for (int r = 0; r < 4; r++) begin
            if (r_vecmode) begin
                lane_a[r] = r_m[r][kk];
                case (kk)
                    2'd0: lane_b[r] = r_a;
                    2'd1: lane_b[r] = r_b;
                    2'd2: lane_b[r] = r_c;
                    default: lane_b[r] = ONE;
                endcase
            end else begin
                lane_a[r] = r_t[r][kk];
                lane_b[r] = r_m[kk][r_col_i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend <= 1'b0;
            o_valid <= 1'b0;
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    r_m[r][c] <= (r == c) ? ONE : 32'sd0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_op <= i_opcode;
                        r_a <= i_operand_a;
                        r_b <= i_operand_b;
                        r_c <= i_operand_c;
                        r_row <= i_element_row;
                        r_col <= i_element_col;
                        r_pend <= 1'b1;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_sat <= 1'b0;
                    r_rx <= '0;
                    r_ry <= '0;
                    r_rz <= '0;
                    r_rot <= '0;
                    r_col_i <= '0;
                    r_k <= '0;
                    r_vecmode <= 1'b0;
                    for (int r = 0; r < 4; r++)
                        for (int c = 0; c < 4; c++)
                            r_t[r][c] <= (r == c) ? ONE : 32'sd0;
                    r_state <= S_MAC;
                    case (r_op)
                        atc_pkg::OP_IDENT: begin
                            for (int r = 0; r < 4; r++)
                                for (int c = 0; c < 4; c++)
                                    r_m[r][c] <= (r == c) ? ONE : 32'sd0;
                            r_state <= S_DONE;
                        end
                        atc_pkg::OP_TRANS: begin
                            r_t[0][3] <= r_a;
                            r_t[1][3] <= r_b;
                            r_t[2][3] <= r_c;
                        end
                        atc_pkg::OP_SCALE: begin
                            r_t[0][0] <= r_a;
                            r_t[1][1] <= r_b;
                            r_t[2][2] <= r_c;
                        end
                        atc_pkg::OP_ROTX: begin r_axis <= 2'd0; r_state <= S_TRIG; end
                        atc_pkg::OP_ROTY: begin r_axis <= 2'd1; r_state <= S_TRIG; end
                        atc_pkg::OP_ROTZ: begin r_axis <= 2'd2; r_state <= S_TRIG; end
                        atc_pkg::OP_XYZROT: begin r_axis <= 2'd2; r_state <= S_TRIG; end
                        atc_pkg::OP_PRJXY: r_t[2][2] <= '0;
                        atc_pkg::OP_PRJXZ: r_t[1][1] <= '0;
                        atc_pkg::OP_PRJYZ: r_t[0][0] <= '0;
                        atc_pkg::OP_MIRXY: r_t[2][2] <= -ONE;
                        atc_pkg::OP_MIRXZ: r_t[1][1] <= -ONE;
                        atc_pkg::OP_MIRYZ: r_t[0][0] <= -ONE;
                        atc_pkg::OP_POINT, atc_pkg::OP_VECTOR: r_vecmode <= 1'b1;
                        atc_pkg::OP_WRITE: begin
                            r_m[r_row][r_col] <= r_a;
                            r_state <= S_DONE;
                        end
                        atc_pkg::OP_READ: begin
                            r_rx <= r_m[r_row][r_col];
                            r_state <= S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_TRIG: r_state <= S_TWAIT;
                S_TWAIT: begin
                    if (cor_done) begin
                        for (int r = 0; r < 4; r++)
                            for (int c = 0; c < 4; c++)
                                r_t[r][c] <= (r == c) ? ONE : 32'sd0;
                        case (r_axis)
                            2'd0: begin
                                r_t[1][1] <= cor_cos; r_t[2][2] <= cor_cos;
                                r_t[1][2] <= -cor_sin; r_t[2][1] <= cor_sin;
                            end
                            2'd1: begin
                                r_t[0][0] <= cor_cos; r_t[2][2] <= cor_cos;
                                r_t[0][2] <= cor_sin; r_t[2][0] <= -cor_sin;
                            end
                            default: begin
                                r_t[0][0] <= cor_cos; r_t[1][1] <= cor_cos;
                                r_t[0][1] <= -cor_sin; r_t[1][0] <= cor_sin;
                            end
                        endcase
                        r_col_i <= '0;
                        r_k <= '0;
                        r_state <= S_WB;
                    end
                end
                S_WB: r_state <= S_MAC;
                S_MAC: begin
                    r_k <= r_k + 3'd1;
                    if (kk == 2'd3) r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (r_k == 3'd5) begin
                        r_k <= '0;
                        for (int r = 0; r < 4; r++)
                            if (lane_sat[r] && !(r_vecmode && r == 3)) r_sat <= 1'b1;
                        if (r_vecmode) begin
                            r_rx <= lane_res[0];
                            r_ry <= lane_res[1];
                            r_rz <= lane_res[2];
                            r_state <= S_DONE;
                        end else begin
                            for (int r = 0; r < 4; r++) r_m[r][r_col_i] <= lane_res[r];
                            r_col_i <= r_col_i + 2'd1;
                            if (r_col_i != 2'd3) r_state <= S_WB;
                            else if (r_op == atc_pkg::OP_XYZROT && r_rot != 2'd2) begin
                                r_rot <= r_rot + 2'd1;
                                r_axis <= r_axis - 2'd1;
                                r_state <= S_TRIG;
                            end else r_state <= S_DONE;
                        end
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_DONE: r_state <= S_OUT;
                S_OUT: begin
                    if (ost_free) begin
                        o_valid <= 1'b1;
                        o_result_x <= r_rx;
                        o_result_y <= r_ry;
                        o_result_z <= r_rz;
                        o_saturated <= r_sat;
                        r_pend <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ATC_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE)
    `ATC_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `ATC_ASSERT_NXT(a_out_from_out, i_clk, i_rst_n, (r_state == S_OUT) && ost_free, o_valid)
    `ATC_ASSERT_IMP(a_cordic_quiet, i_clk, i_rst_n, cor_done, r_state == S_TWAIT)
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the 4x4 homogeneous transform composer.
`timescale 1ns / 1ps

class transform_scoreboard;
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sat;
    } result_t;

    localparam logic signed [31:0] UNIT = 32'sd65536;

    logic signed [31:0] mat [4][4];
    bit                 clip;
    result_t            pending [$];
    int                 mismatches;
    int                 checked;
    int                 noted;

    function new();
        home();
        mismatches = 0;
        checked = 0;
        noted = 0;
    endfunction

    function void home();
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                mat[r][c] = (r == c) ? UNIT : 32'sd0;
    endfunction

    function logic signed [31:0] dot(logic signed [31:0] a [4], logic signed [31:0] b [4],
                                     int n);
        logic signed [127:0] acc;
        logic signed [127:0] pa;
        logic signed [127:0] pb;
        acc = 0;
        for (int k = 0; k < n; k++) begin
            pa = a[k];
            pb = b[k];
            acc = acc + pa * pb;
        end
        acc = (acc + 128'sd32768) >>> 16;
        if (acc > 128'sd2147483647) begin
            clip = 1'b1;
            return 32'sh7fffffff;
        end
        if (acc < -128'sd2147483648) begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return acc[31:0];
    endfunction

    function void premultiply(logic signed [31:0] t [4][4]);
        logic signed [31:0] res [4][4];
        logic signed [31:0] column [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) column[k] = mat[k][c];
            for (int r = 0; r < 4; r++) res[r][c] = dot(t[r], column, 4);
        end
        mat = res;
    endfunction

    function void identity_into(output logic signed [31:0] t [4][4]);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[r][c] = (r == c) ? UNIT : 32'sd0;
    endfunction

    function void sincos(logic signed [31:0] deg, output logic signed [31:0] s,
                         output logic signed [31:0] co);
        logic signed [63:0] arctan [32];
        logic signed [63:0] full;
        logic signed [63:0] half;
        logic signed [63:0] quarter;
        logic signed [63:0] r;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] cv;
        logic signed [63:0] sv;
        bit                 neg;
        arctan = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                   16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
                   65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
                   16, 8, 4, 2, 1, 0};
        full = 64'sd360 * 65536;
        half = 64'sd180 * 65536;
        quarter = 64'sd90 * 65536;
        neg = 0;
        r = deg;
        r = r % full;
        if (r < 0) r = r + full;
        if (r >= half) r = r - full;
        if (r > quarter) begin
            r = r - half;
            neg = 1;
        end else if (r < -quarter) begin
            r = r + half;
            neg = 1;
        end
        z = (r * atc_pkg::DEG_TO_RAD_Q32 + 64'sd131072) >>> 18;
        x = 64'sd1 <<< 30;
        y = 0;
        for (int i = 0; i < 20; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctan[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctan[i];
            end
        end
        cv = (x * atc_pkg::CORDIC_GAIN_Q30 + (64'sd1 <<< 29)) >>> 30;
        sv = (y * atc_pkg::CORDIC_GAIN_Q30 + (64'sd1 <<< 29)) >>> 30;
        cv = (cv + 64'sd8192) >>> 14;
        sv = (sv + 64'sd8192) >>> 14;
        if (cv > 65536) cv = 65536;
        if (cv < -65536) cv = -65536;
        if (sv > 65536) sv = 65536;
        if (sv < -65536) sv = -65536;
        if (neg) begin
            cv = -cv;
            sv = -sv;
        end
        s = sv[31:0];
        co = cv[31:0];
    endfunction

    function void rotate(int axis, logic signed [31:0] deg);
        logic signed [31:0] t [4][4];
        logic signed [31:0] s;
        logic signed [31:0] co;
        int p;
        int q;
        p = (axis == 0) ? 1 : 0;
        q = (axis == 2) ? 1 : 2;
        sincos(deg, s, co);
        identity_into(t);
        t[p][p] = co;
        t[q][q] = co;
        if (axis == 1) begin
            t[p][q] = s;
            t[q][p] = -s;
        end else begin
            t[p][q] = -s;
            t[q][p] = s;
        end
        premultiply(t);
    endfunction

    function void note(logic [4:0] op, logic signed [31:0] a, logic signed [31:0] b,
                       logic signed [31:0] c, logic [1:0] row, logic [1:0] col);
        logic signed [31:0] t [4][4];
        logic signed [31:0] v [4];
        logic signed [31:0] m [4];
        result_t            res;
        res = '{0, 0, 0, 0};
        clip = 0;
        identity_into(t);
        case (op)
            atc_pkg::OP_IDENT: home();
            atc_pkg::OP_TRANS: begin
                t[0][3] = a;
                t[1][3] = b;
                t[2][3] = c;
                premultiply(t);
            end
            atc_pkg::OP_SCALE: begin
                t[0][0] = a;
                t[1][1] = b;
                t[2][2] = c;
                premultiply(t);
            end
            atc_pkg::OP_ROTX: rotate(0, a);
            atc_pkg::OP_ROTY: rotate(1, a);
            atc_pkg::OP_ROTZ: rotate(2, a);
            atc_pkg::OP_PRJXY, atc_pkg::OP_PRJXZ, atc_pkg::OP_PRJYZ: begin
                t[atc_pkg::OP_PRJYZ - op][atc_pkg::OP_PRJYZ - op] = 0;
                premultiply(t);
            end
            atc_pkg::OP_MIRXY, atc_pkg::OP_MIRXZ, atc_pkg::OP_MIRYZ: begin
                t[atc_pkg::OP_MIRYZ - op][atc_pkg::OP_MIRYZ - op] = -UNIT;
                premultiply(t);
            end
            atc_pkg::OP_POINT, atc_pkg::OP_VECTOR: begin
                v = '{a, b, c, UNIT};
                for (int r = 0; r < 3; r++) begin
                    for (int k = 0; k < 4; k++) m[k] = mat[r][k];
                    if (r == 0) res.x = dot(m, v, (op == atc_pkg::OP_POINT) ? 4 : 3);
                    else if (r == 1) res.y = dot(m, v, (op == atc_pkg::OP_POINT) ? 4 : 3);
                    else res.z = dot(m, v, (op == atc_pkg::OP_POINT) ? 4 : 3);
                end
            end
            atc_pkg::OP_WRITE: mat[row][col] = a;
            atc_pkg::OP_READ: res.x = mat[row][col];
            atc_pkg::OP_XYZROT: begin
                rotate(2, c);
                rotate(1, b);
                rotate(0, a);
            end
            default: ;
        endcase
        res.sat = clip;
        pending.push_back(res);
        noted++;
    endfunction

    function void check(logic signed [31:0] x, logic signed [31:0] y,
                        logic signed [31:0] z, logic sat);
        result_t want;
        checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: result beat with nothing expected");
            return;
        end
        want = pending.pop_front();
        if (x !== want.x || y !== want.y || z !== want.z || sat !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: beat %0d expected %0d %0d %0d sat %0d, got %0d %0d %0d sat %0d",
                         checked, want.x, want.y, want.z, want.sat, x, y, z, sat);
        end
    endfunction
endclass

module testbench;
    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_valid = 0;
    logic              o_ready;
    logic [4:0]        i_opcode = 0;
    logic signed [31:0] i_operand_a = 0;
    logic signed [31:0] i_operand_b = 0;
    logic signed [31:0] i_operand_c = 0;
    logic [1:0]        i_element_row = 0;
    logic [1:0]        i_element_col = 0;
    logic              o_valid;
    logic              i_ready = 0;
    logic signed [31:0] o_result_x;
    logic signed [31:0] o_result_y;
    logic signed [31:0] o_result_z;
    logic              o_saturated;

    transform_scoreboard board = new();
    int  beat_count = 0;
    bit  calm = 0;
    bit  done_sending = 0;

    affine_transform_composer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .i_operand_c(i_operand_c), .i_element_row(i_element_row),
        .i_element_col(i_element_col), .o_valid(o_valid), .i_ready(i_ready),
        .o_result_x(o_result_x), .o_result_y(o_result_y), .o_result_z(o_result_z),
        .o_saturated(o_saturated)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("testbench NOT OK");
        $finish;
    end

    task automatic send(logic [4:0] op, logic signed [31:0] a, logic signed [31:0] b,
                        logic signed [31:0] c, logic [1:0] row, logic [1:0] col);
        if (!calm && $urandom_range(0, 99) < 19) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_opcode <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        i_operand_c <= c;
        i_element_row <= row;
        i_element_col <= col;
        do @(posedge i_clk); while (!o_ready);
        board.note(op, a, b, c, row, col);
        beat_count++;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
            2: return $signed($urandom_range(0, 32'h20000)) - 32'sh10000 + 32'sh10000;
            default: return $signed($urandom_range(0, 720 * 65536)) - 360 * 65536;
        endcase
    endfunction

    task automatic random_item();
        logic [4:0] op;
        int         roll;
        roll = $urandom_range(0, 99);
        if (roll < 6) op = atc_pkg::OP_IDENT;
        else if (roll < 92) op = 5'($urandom_range(1, 16));
        else op = 5'($urandom_range(17, 31));
        send(op, pick_value(), pick_value(), pick_value(), 2'($urandom), 2'($urandom));
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                board.check(o_result_x, o_result_y, o_result_z, o_saturated);
            i_ready <= calm || ($urandom_range(0, 99) >= 19);
        end
    end

    initial begin
        int wait_cycles;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send(atc_pkg::OP_READ, 0, 0, 0, 2'd3, 2'd3);
        send(atc_pkg::OP_POINT, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0);
        send(atc_pkg::OP_VECTOR, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 0);
        send(atc_pkg::OP_TRANS, 32'sh00018000, -32'sh00028000, 32'sh7fffffff, 0, 0);
        send(atc_pkg::OP_POINT, 32'sh00010000, 32'sh00020000, 32'sh00030000, 0, 0);
        send(atc_pkg::OP_VECTOR, 32'sh00010000, 32'sh00020000, 32'sh00030000, 0, 0);
        send(atc_pkg::OP_WRITE, 32'sh80000000, 0, 0, 2'd0, 2'd0);
        send(atc_pkg::OP_MIRYZ, 0, 0, 0, 0, 0);
        send(atc_pkg::OP_READ, 0, 0, 0, 2'd0, 2'd0);
        send(atc_pkg::OP_IDENT, 32'sh7fffffff, 0, 0, 0, 0);
        send(atc_pkg::OP_SCALE, 32'sh80000000, 32'sh7fffffff, 32'sh00008000, 0, 0);
        send(atc_pkg::OP_IDENT, 0, 0, 0, 0, 0);
        send(atc_pkg::OP_ROTX, 32'sh005a0000, 0, 0, 0, 0);
        send(atc_pkg::OP_ROTY, -32'sh00b40000, 0, 0, 0, 0);
        send(atc_pkg::OP_ROTZ, 32'sh7fffffff, 0, 0, 0, 0);
        send(atc_pkg::OP_ROTZ, 32'sh80000000, 0, 0, 0, 0);
        send(atc_pkg::OP_ROTX, 32'sh01680000, 0, 0, 0, 0);
        send(atc_pkg::OP_XYZROT, 32'sh001e0000, -32'sh002d0000, 32'sh00b40000, 0, 0);
        send(atc_pkg::OP_MIRXY, 0, 0, 0, 0, 0);
        send(atc_pkg::OP_MIRXZ, 0, 0, 0, 0, 0);
        send(atc_pkg::OP_PRJXY, 0, 0, 0, 0, 0);
        send(atc_pkg::OP_PRJXZ, 0, 0, 0, 0, 0);
        send(atc_pkg::OP_PRJYZ, 0, 0, 0, 0, 0);
        send(5'd17, 32'sh7fffffff, 0, 0, 0, 0);
        send(5'd31, 0, 0, 0, 2'd3, 2'd3);
        send(atc_pkg::OP_READ, 0, 0, 0, 2'd2, 2'd1);

        for (int n = 0; n < 1000; n++) begin
            calm = (n >= 400 && n < 550);
            random_item();
        end
        calm = 0;
        i_valid <= 0;

        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (300) @(posedge i_clk);

        $display("Sent %0d command beats covering all opcodes with random stalls;",
                 beat_count);
        $display("checked %0d result beats, %0d mismatches, %0d still expected.",
                 board.checked, board.mismatches, board.pending.size());
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
